// File: sv/dnt_pkg.sv
// Shared types, constants and tables of the decimal number tokenizer.
package dnt_pkg;

  localparam int CHAR_W   = 8;
  localparam int STATUS_W = 2;
  localparam int VALUE_W  = 48;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_COMMENTS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DECIMAL  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_SAT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD = 2'd2;

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_HASH  = 8'h23;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

  // Widths that cover the whole legal range of the top-level parameters.
  localparam int INT_W_MAX  = 31;
  localparam int FACC_W_MAX = 24;
  localparam int CNT_W      = 3;
  localparam int DEN_W      = 24;
  localparam int REM_W      = 25;
  localparam int QUO_W_MAX  = 24;

  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = 2;
  localparam int QCNT_W  = 3;
  localparam int PUSH_W  = 2;

  typedef enum logic [2:0] {
    PH_BLANK,
    PH_HASH,
    PH_SLASH,
    PH_SIGN,
    PH_INT,
    PH_FRAC
  } phase_t;

  typedef struct packed {
    logic                  bad;
    logic                  neg;
    logic                  ovf;
    logic [INT_W_MAX-1:0]  int_acc;
    logic [FACC_W_MAX-1:0] frac_acc;
    logic [CNT_W-1:0]      frac_cnt;
  } token_t;

  typedef struct packed {
    logic [PUSH_W-1:0] cnt;
    token_t            data0;
    token_t            data1;
  } q_push_t;

  typedef struct packed {
    logic                 bad;
    logic                 neg;
    logic                 sat;
    logic [INT_W_MAX-1:0] int_acc;
    logic [CNT_W-1:0]     frac_cnt;
    logic [REM_W-1:0]     rem;
    logic [QUO_W_MAX-1:0] quo;
  } div_stage_t;

  function automatic logic [DEN_W-1:0] pow10(input logic [CNT_W-1:0] n);
    logic [DEN_W-1:0] d;
    case (n)
      3'd1:    d = 24'd10;
      3'd2:    d = 24'd100;
      3'd3:    d = 24'd1000;
      3'd4:    d = 24'd10000;
      3'd5:    d = 24'd100000;
      3'd6:    d = 24'd1000000;
      3'd7:    d = 24'd10000000;
      default: d = 24'd1;
    endcase
    return d;
  endfunction

endpackage

// File: sv/dnt_if.sv
// Handshake channel interfaces for text bytes and parsed numbers.
interface dnt_in_if;
  import dnt_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  modport source (output valid, output char_code, input ready);
  modport sink (input valid, input char_code, output ready);
endinterface

interface dnt_out_if;
  import dnt_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [STATUS_W-1:0]        status;
  logic signed [VALUE_W-1:0]  number_value;
  modport source (output valid, output status, output number_value, input ready);
  modport sink (input valid, input status, input number_value, output ready);
endinterface

// File: sv/dnt_front.sv
// Character scanner: classifies each byte and builds number tokens.
module dnt_front #(
  parameter int INT_BITS        = 31,
  parameter int MAX_FRAC_DIGITS = 5
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [dnt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dnt_pkg::CFG_DATA_W-1:0] cfg_wdata,
  dnt_in_if.sink                      in_ch,
  input  logic                        q_space,
  output dnt_pkg::q_push_t            push
);
  import dnt_pkg::*;

  localparam int FACC_W = $clog2(10 ** MAX_FRAC_DIGITS);
  localparam int ACC_W  = INT_BITS + 4;
  localparam int FW     = FACC_W + 4;
  localparam logic [ACC_W-1:0] INT_LIMIT = ACC_W'((64'd1 << INT_BITS) - 64'd1);

  phase_t              phase_r, phase_nxt;
  logic                neg_r, neg_nxt;
  logic [INT_BITS-1:0] int_r, int_nxt;
  logic [FACC_W-1:0]   frac_r, frac_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                seen_r, seen_nxt;
  logic                ovf_r, ovf_nxt;
  logic                cmt_en_r;
  logic                dec_mode_r;

  logic [CHAR_W-1:0]   c;
  logic                accept;
  logic                num_char, is_blank, is_eol, dot_ok, blank_bad;
  logic                terminate, do_blank;
  logic [3:0]          digit;
  logic [ACC_W-1:0]    int_sum;
  logic                int_sat;
  logic [INT_BITS-1:0] int_add;
  logic [FW-1:0]       frac_sum;
  token_t              first_tok, bad_tok;
  logic                first_v, second_v;

  assign c        = in_ch.char_code;
  assign in_ch.ready = q_space;
  assign accept   = in_ch.valid && q_space;

  assign num_char = (c >= CH_ZERO) && (c <= CH_NINE);
  assign digit    = c[3:0];
  assign is_eol   = (c == CH_LF) || (c == CH_CR) || (c == CH_NUL);
  assign is_blank = is_eol || (c == CH_SPACE) || (c == CH_TAB);
  assign dot_ok   = (c == CH_DOT) && dec_mode_r;
  assign blank_bad = !is_blank && !(cmt_en_r && ((c == CH_HASH) || (c == CH_SLASH)))
                     && (c != CH_MINUS) && !num_char && !dot_ok;

  // Accumulate one integer digit, saturating at the largest integer part.
  assign int_sum = (ACC_W'(int_r) << 3) + (ACC_W'(int_r) << 1) + ACC_W'(digit);
  assign int_sat = int_sum > INT_LIMIT;
  assign int_add = int_sat ? INT_LIMIT[INT_BITS-1:0] : int_sum[INT_BITS-1:0];
  assign frac_sum = (FW'(frac_r) << 3) + (FW'(frac_r) << 1) + FW'(digit);

  always_comb begin
    case (phase_r)
      PH_SLASH: terminate = (c != CH_SLASH);
      PH_SIGN:  terminate = !num_char && !dot_ok;
      PH_INT:   terminate = !num_char && !dot_ok;
      PH_FRAC:  terminate = !num_char;
      default:  terminate = 1'b0;
    endcase
  end

  assign do_blank = (phase_r == PH_BLANK) || terminate;

  // Next state.
  always_comb begin
    phase_nxt = phase_r;
    neg_nxt   = neg_r;
    int_nxt   = int_r;
    frac_nxt  = frac_r;
    cnt_nxt   = cnt_r;
    seen_nxt  = seen_r;
    ovf_nxt   = ovf_r;
    case (phase_r)
      PH_HASH: begin
        if (is_eol) phase_nxt = PH_BLANK;
      end
      PH_SLASH: begin
        if (c == CH_SLASH) phase_nxt = PH_HASH;
      end
      PH_SIGN, PH_INT: begin
        if (num_char) begin
          int_nxt   = int_add;
          ovf_nxt   = ovf_r | int_sat;
          seen_nxt  = 1'b1;
          phase_nxt = PH_INT;
        end else if (dot_ok) begin
          phase_nxt = PH_FRAC;
        end
      end
      PH_FRAC: begin
        if (num_char) begin
          seen_nxt = 1'b1;
          if (cnt_r < CNT_W'(MAX_FRAC_DIGITS)) begin
            frac_nxt = frac_sum[FACC_W-1:0];
            cnt_nxt  = cnt_r + CNT_W'(1);
          end
        end
      end
      default: ;
    endcase
    if (do_blank) begin
      phase_nxt = PH_BLANK;
      neg_nxt   = 1'b0;
      int_nxt   = '0;
      frac_nxt  = '0;
      cnt_nxt   = '0;
      seen_nxt  = 1'b0;
      ovf_nxt   = 1'b0;
      if (!is_blank) begin
        if (cmt_en_r && (c == CH_HASH)) begin
          phase_nxt = PH_HASH;
        end else if (cmt_en_r && (c == CH_SLASH)) begin
          phase_nxt = PH_SLASH;
        end else if (c == CH_MINUS) begin
          neg_nxt   = 1'b1;
          phase_nxt = PH_SIGN;
        end else if (num_char) begin
          int_nxt   = INT_BITS'(digit);
          seen_nxt  = 1'b1;
          phase_nxt = PH_INT;
        end else if (dot_ok) begin
          phase_nxt = PH_FRAC;
        end
      end
    end
  end

  // Token outputs: the number being ended first, then a bad start byte.
  always_comb begin
    bad_tok       = '0;
    bad_tok.bad   = 1'b1;
    first_tok          = '0;
    first_tok.bad      = (phase_r == PH_SLASH) || (phase_r == PH_SIGN) ||
                         ((phase_r == PH_FRAC) && !seen_r);
    first_tok.neg      = neg_r;
    first_tok.ovf      = ovf_r;
    first_tok.int_acc  = INT_W_MAX'(int_r);
    first_tok.frac_acc = FACC_W_MAX'(frac_r);
    first_tok.frac_cnt = cnt_r;
    first_v   = terminate;
    second_v  = do_blank && blank_bad;
    push.cnt   = accept ? (PUSH_W'(first_v) + PUSH_W'(second_v)) : '0;
    push.data0 = first_v ? first_tok : bad_tok;
    push.data1 = bad_tok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_BLANK;
      neg_r      <= 1'b0;
      int_r      <= '0;
      frac_r     <= '0;
      cnt_r      <= '0;
      seen_r     <= 1'b0;
      ovf_r      <= 1'b0;
      cmt_en_r   <= 1'b1;
      dec_mode_r <= 1'b1;
    end else begin
      if (accept) begin
        phase_r <= phase_nxt;
        neg_r   <= neg_nxt;
        int_r   <= int_nxt;
        frac_r  <= frac_nxt;
        cnt_r   <= cnt_nxt;
        seen_r  <= seen_nxt;
        ovf_r   <= ovf_nxt;
      end
      if (cfg_we && (cfg_index == REG_COMMENTS)) cmt_en_r <= cfg_wdata[0];
      if (cfg_we && (cfg_index == REG_DECIMAL)) dec_mode_r <= cfg_wdata[0];
    end
  end

endmodule

// File: sv/dnt_queue.sv
// Token queue that takes up to two tokens per cycle and hands out one.
module dnt_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  dnt_pkg::q_push_t push,
  output logic             space,
  output logic             head_v,
  output dnt_pkg::token_t  head,
  input  logic             pop
);
  import dnt_pkg::*;

  token_t            mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_pop;

  assign head_v = (cnt_r != '0);
  assign head   = mem_r[rd_ptr_r];
  assign space  = cnt_r <= QCNT_W'(QDEPTH - 2);
  assign do_pop = pop && head_v;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + QPTR_W'(push.cnt);
      rd_ptr_r <= rd_ptr_r + QPTR_W'(do_pop);
      cnt_r    <= cnt_r + QCNT_W'(push.cnt) - QCNT_W'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.cnt != '0) mem_r[wr_ptr_r] <= push.data0;
    if (push.cnt == PUSH_W'(2)) mem_r[wr_ptr_r + 1'b1] <= push.data1;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QDEPTH))
    else $error("token queue holds more entries than it has");

  a_push_space: assert property (@(posedge clk) disable iff (!rst_n)
    (push.cnt != '0) |-> space)
    else $error("token pushed into a queue without room for two");

endmodule

// File: sv/dnt_back.sv
// Converter pipeline: fraction division, rounding, clamping and sign.
module dnt_back #(
  parameter int INT_BITS  = 31,
  parameter int FRAC_BITS = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            head_v,
  input  dnt_pkg::token_t head,
  output logic            pop,
  dnt_out_if.source       out_ch
);
  import dnt_pkg::*;

  localparam int NST   = FRAC_BITS + 1;
  localparam int MAG_W = INT_BITS + FRAC_BITS + 1;
  localparam int VAL_W = (MAG_W > VALUE_W) ? MAG_W : VALUE_W;
  localparam logic [MAG_W-1:0] MAG_LIMIT =
    MAG_W'((64'd1 << (INT_BITS + FRAC_BITS)) - 64'd1);

  div_stage_t       stage_r [NST];
  logic [NST-1:0]   v_r;
  div_stage_t       load;

  logic             mv_r, mbad_r, mneg_r, msat_r;
  logic [MAG_W-1:0] mag_r;

  logic                ov_r;
  logic [STATUS_W-1:0] status_r;
  logic [VALUE_W-1:0]  value_r;

  logic                en;
  logic [DEN_W-1:0]    den_last;
  logic                round_up;
  logic [FRAC_BITS:0]  frac_q;
  logic [MAG_W-1:0]    mag_nxt;
  logic                over;
  logic [VAL_W-1:0]    val_abs, val_sgn;
  logic [STATUS_W-1:0] status_nxt;
  logic [VALUE_W-1:0]  value_nxt;

  // One restoring division step: shift the remainder, subtract if it fits.
  function automatic div_stage_t div_step(input div_stage_t s);
    div_stage_t       o;
    logic [REM_W-1:0] rs;
    logic [REM_W-1:0] den;
    logic             ge;
    o   = s;
    rs  = {s.rem[REM_W-2:0], 1'b0};
    den = REM_W'(pow10(s.frac_cnt));
    ge  = rs >= den;
    o.rem = ge ? (rs - den) : rs;
    o.quo = {s.quo[QUO_W_MAX-2:0], ge};
    return o;
  endfunction

  assign en  = !ov_r || out_ch.ready;
  assign pop = head_v && en;

  always_comb begin
    load          = '0;
    load.bad      = head.bad;
    load.neg      = head.neg;
    load.sat      = head.ovf;
    load.int_acc  = head.int_acc;
    load.frac_cnt = head.frac_cnt;
    load.rem      = REM_W'(head.frac_acc);
  end

  // Round half up, then place the integer part above the fraction.
  always_comb begin
    den_last = pow10(stage_r[NST-1].frac_cnt);
    round_up = {stage_r[NST-1].rem, 1'b0} >= (REM_W + 1)'(den_last);
    frac_q   = (FRAC_BITS + 1)'(stage_r[NST-1].quo[FRAC_BITS-1:0]) +
               (FRAC_BITS + 1)'(round_up);
    mag_nxt  = (MAG_W'(stage_r[NST-1].int_acc[INT_BITS-1:0]) << FRAC_BITS) +
               MAG_W'(frac_q);
  end

  always_comb begin
    over    = mag_r > MAG_LIMIT;
    val_abs = VAL_W'(over ? MAG_LIMIT : mag_r);
    val_sgn = mneg_r ? (VAL_W'(0) - val_abs) : val_abs;
    if (mbad_r) begin
      status_nxt = ST_BAD;
      value_nxt  = '0;
    end else begin
      status_nxt = (msat_r || over) ? ST_SAT : ST_OK;
      value_nxt  = val_sgn[VALUE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r  <= '0;
      mv_r <= 1'b0;
      ov_r <= 1'b0;
    end else if (en) begin
      v_r  <= {v_r[NST-2:0], head_v};
      mv_r <= v_r[NST-1];
      ov_r <= mv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stage_r[0] <= load;
      for (int k = 0; k < NST - 1; k++) begin
        stage_r[k+1] <= div_step(stage_r[k]);
      end
      mbad_r   <= stage_r[NST-1].bad;
      mneg_r   <= stage_r[NST-1].neg;
      msat_r   <= stage_r[NST-1].sat;
      mag_r    <= mag_nxt;
      status_r <= status_nxt;
      value_r  <= value_nxt;
    end
  end

  assign out_ch.valid        = ov_r;
  assign out_ch.status       = status_r;
  assign out_ch.number_value = value_r;

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && (status_r == ST_BAD)) |-> (value_r == '0))
    else $error("malformed item carries a nonzero value");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_ch.ready) |=> ($stable(v_r) && $stable(mv_r)))
    else $error("pipeline advanced while the output was stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> ((status_r == ST_OK) || (status_r == ST_SAT) || (status_r == ST_BAD)))
    else $error("result status outside the defined codes");

endmodule

// File: sv/decimal_number_tokenizer.sv
// Top level of the decimal number tokenizer: scanner, token queue and converter.
//
// The block reads one ASCII byte per item and produces signed fixed-point
// numbers with FRAC_BITS fraction bits (status ok or saturated) and malformed
// token reports (value zero). A byte is taken in every cycle in which the
// token queue has room for two tokens, so a steady stream runs at one byte
// per cycle as long as results are taken. Each byte can end a number and be
// rejected itself, so it gives zero, one or two results. After a token leaves
// the queue, the converter divides the decimal fraction by its power of ten
// in a pipeline that resolves one quotient bit per stage, then rounds, clamps
// and applies the sign in two more stages. The converter accepts a new token
// every cycle while its output register is free or being emptied; one token
// per cycle is the converter's limit, and a stalled output holds the whole
// pipeline. Configuration writes (comment skipping, decimal fractions) are
// taken in the cycle in which cfg_we is high and should be made only while
// no text is in flight.
module decimal_number_tokenizer #(
  parameter int FRAC_BITS       = 16,
  parameter int INT_BITS        = 31,
  parameter int MAX_FRAC_DIGITS = 5
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [dnt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dnt_pkg::CFG_DATA_W-1:0] cfg_wdata,
  dnt_in_if.sink                         in_ch,
  dnt_out_if.source                      out_ch
);
  import dnt_pkg::*;

  // Tokens written by the scanner, at most two per accepted item.
  q_push_t push;
  logic    q_space;
  logic    head_v;
  token_t  head;
  logic    pop;

  // The scanner holds the text state and the number being collected.
  dnt_front #(
    .INT_BITS        (INT_BITS),
    .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .q_space   (q_space),
    .push      (push)
  );

  // The queue lets the scanner run ahead while the converter is stalled.
  dnt_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .space  (q_space),
    .head_v (head_v),
    .head   (head),
    .pop    (pop)
  );

  // The converter turns each token into one result item.
  dnt_back #(
    .INT_BITS  (INT_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head_v (head_v),
    .head   (head),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

// File: verif/dnt_checker.sv
// Scoreboard that predicts and checks every parsed number of the tokenizer.
module dnt_checker #(
  parameter int FRAC_BITS       = 16,
  parameter int INT_BITS        = 31,
  parameter int MAX_FRAC_DIGITS = 5
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [dnt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dnt_pkg::CFG_DATA_W-1:0] cfg_wdata,
  dnt_in_if                              in_mon,
  dnt_out_if                             out_mon,
  output int                             fail_count,
  output int                             n_pending,
  output int                             n_results,
  output int                             n_sat,
  output int                             n_bad
);
  timeunit 1ns;
  timeprecision 1ps;
  import dnt_pkg::*;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  value;
  } number_t;

  number_t expected_q[$];

  // Mirror of the register settings and of the scanner state.
  logic              comments_on;
  logic              decimal_on;
  phase_t            scan;
  logic              minus;
  logic [INT_BITS-1:0] int_part;
  logic [23:0]       frac_digits;
  logic [2:0]        frac_count;
  logic              any_digit;
  logic              int_clipped;
  int                results_seen;
  int                sat_seen;
  int                bad_seen;

  task automatic report_mismatch(input string what);
    fail_count++;
    if (fail_count <= 40) $display("MISMATCH at %0t: %s", $time, what);
  endtask

  function automatic bit digit_char(input logic [CHAR_W-1:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic void clear_token();
    minus       = 1'b0;
    int_part    = '0;
    frac_digits = '0;
    frac_count  = '0;
    any_digit   = 1'b0;
    int_clipped = 1'b0;
  endfunction

  function automatic void reject_token();
    number_t r;
    clear_token();
    scan     = PH_BLANK;
    r.status = ST_BAD;
    r.value  = '0;
    expected_q.insert(expected_q.size(), r);
  endfunction

  // Scale the decimal fraction to binary, add the integer part, clamp and sign.
  function automatic void finish_number();
    number_t     r;
    logic [63:0] den;
    logic [63:0] frac;
    logic [63:0] mag;
    logic [63:0] top;
    logic        clipped;
    clipped = int_clipped;
    top     = (64'd1 << (INT_BITS + FRAC_BITS)) - 64'd1;
    frac    = '0;
    if (frac_count != 0) begin
      den = 64'd1;
      repeat (frac_count) den = den * 64'd10;
      frac = ((64'(frac_digits) << FRAC_BITS) + den / 64'd2) / den;
    end
    mag = (64'(int_part) << FRAC_BITS) + frac;
    if (mag > top) begin
      mag     = top;
      clipped = 1'b1;
    end
    if (minus) mag = 64'd0 - mag;
    r.status = clipped ? ST_SAT : ST_OK;
    r.value  = mag[VALUE_W-1:0];
    expected_q.insert(expected_q.size(), r);
    clear_token();
    scan = PH_BLANK;
  endfunction

  function automatic void add_int_digit(input logic [CHAR_W-1:0] c);
    logic [63:0] v;
    v = 64'(int_part) * 64'd10 + 64'(c - CH_ZERO);
    if (v > (64'd1 << INT_BITS) - 64'd1) begin
      v           = (64'd1 << INT_BITS) - 64'd1;
      int_clipped = 1'b1;
    end
    int_part  = v[INT_BITS-1:0];
    any_digit = 1'b1;
  endfunction

  // A byte seen between tokens: skip it, open a comment, start a number or reject it.
  function automatic void start_byte(input logic [CHAR_W-1:0] c);
    scan = PH_BLANK;
    if (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF || c == CH_NUL) return;
    if (comments_on && c == CH_HASH) begin
      scan = PH_HASH;
      return;
    end
    if (comments_on && c == CH_SLASH) begin
      scan = PH_SLASH;
      return;
    end
    clear_token();
    if (c == CH_MINUS) begin
      minus = 1'b1;
      scan  = PH_SIGN;
    end else if (digit_char(c)) begin
      int_part  = INT_BITS'(c - CH_ZERO);
      any_digit = 1'b1;
      scan      = PH_INT;
    end else if (c == CH_DOT && decimal_on) begin
      scan = PH_FRAC;
    end else begin
      reject_token();
    end
  endfunction

  function automatic void predict_byte(input logic [CHAR_W-1:0] c);
    case (scan)
      PH_HASH: begin
        if (c == CH_LF || c == CH_CR || c == CH_NUL) scan = PH_BLANK;
      end
      PH_SLASH: begin
        if (c == CH_SLASH) begin
          scan = PH_HASH;
        end else begin
          reject_token();
          start_byte(c);
        end
      end
      PH_SIGN: begin
        if (digit_char(c)) begin
          add_int_digit(c);
          scan = PH_INT;
        end else if (c == CH_DOT && decimal_on) begin
          scan = PH_FRAC;
        end else begin
          reject_token();
          start_byte(c);
        end
      end
      PH_INT: begin
        if (digit_char(c)) begin
          add_int_digit(c);
        end else if (c == CH_DOT && decimal_on) begin
          scan = PH_FRAC;
        end else begin
          finish_number();
          start_byte(c);
        end
      end
      PH_FRAC: begin
        if (digit_char(c)) begin
          any_digit = 1'b1;
          if (frac_count < MAX_FRAC_DIGITS) begin
            frac_digits = frac_digits * 24'd10 + 24'(c - CH_ZERO);
            frac_count++;
          end
        end else begin
          if (any_digit) finish_number();
          else reject_token();
          start_byte(c);
        end
      end
      default: begin
        start_byte(c);
      end
    endcase
  endfunction

  task automatic check_result(input logic [STATUS_W-1:0] st, input logic [VALUE_W-1:0] v);
    number_t want;
    results_seen++;
    if (st == ST_SAT) sat_seen++;
    if (st == ST_BAD) bad_seen++;
    if (expected_q.size() == 0) begin
      report_mismatch($sformatf("unexpected result status %0d value %0h", st, v));
      return;
    end
    want = expected_q.pop_front();
    if (st !== want.status)
      report_mismatch($sformatf("status %0d, expected %0d", st, want.status));
    if (v !== want.value)
      report_mismatch($sformatf("value %0h, expected %0h", v, want.value));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      comments_on = 1'b1;
      decimal_on  = 1'b1;
      scan        = PH_BLANK;
      clear_token();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_COMMENTS) comments_on = cfg_wdata[0];
        else if (cfg_index == REG_DECIMAL) decimal_on = cfg_wdata[0];
      end
      if (in_mon.valid && in_mon.ready) predict_byte(in_mon.char_code);
      if (out_mon.valid && out_mon.ready) check_result(out_mon.status, out_mon.number_value);
    end
    n_pending <= expected_q.size();
    n_results <= results_seen;
    n_sat     <= sat_seen;
    n_bad     <= bad_seen;
  end

endmodule

// File: verif/tb.sv
// Testbench top: drives text bytes and register writes into the tokenizer.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dnt_pkg::*;

  localparam int FRAC_BITS       = 16;
  localparam int INT_BITS        = 31;
  localparam int MAX_FRAC_DIGITS = 5;
  // Wait long enough for a token's trip through the converter twice, plus some
  // margin, before touching the registers or ending the run.
  localparam int SETTLE = 2 * (FRAC_BITS + 3) + 8;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  dnt_in_if  in_ch ();
  dnt_out_if out_ch ();

  int fail_count;
  int n_pending;
  int n_results;
  int n_sat;
  int n_bad;

  // Percentage of cycles in which the sender holds back or the receiver stalls.
  int src_idle_pct;
  int snk_idle_pct;
  int n_bytes;

  decimal_number_tokenizer #(
    .FRAC_BITS       (FRAC_BITS),
    .INT_BITS        (INT_BITS),
    .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // The checker sits beside the block, watches both channels and the register
  // port, and hands back its failure count and the number of results in flight.
  dnt_checker #(
    .FRAC_BITS       (FRAC_BITS),
    .INT_BITS        (INT_BITS),
    .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
  ) i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .fail_count (fail_count),
    .n_pending  (n_pending),
    .n_results  (n_results),
    .n_sat      (n_sat),
    .n_bad      (n_bad)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // The receiver decides afresh at every edge whether it takes a result.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= rst_n && ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // Offers one byte and returns at the edge where it is accepted. Valid is
  // only lowered by an idle cycle, so back-to-back bytes keep it high.
  task automatic send_byte(input logic [CHAR_W-1:0] c);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.char_code <= c;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    n_bytes++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_digit();
    send_byte(CH_ZERO + CHAR_W'($urandom_range(9)));
  endtask

  function automatic logic [CHAR_W-1:0] pick_blank();
    case ($urandom_range(3))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_CR;
      default: return CH_LF;
    endcase
  endfunction

  // Stops offering bytes and waits until every predicted result has come back.
  // The first edge lets the checker count the byte accepted last.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
  endtask

  // Registers are only written once the block has gone quiet.
  task automatic set_mode(input logic [CFG_DATA_W-1:0] comments,
                          input logic [CFG_DATA_W-1:0] decimals);
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_COMMENTS;
    cfg_wdata <= comments;
    @(posedge clk);
    cfg_index <= REG_DECIMAL;
    cfg_wdata <= decimals;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // A signed number: mostly short, now and then long enough to saturate, with
  // an optional fraction that may run past the digits that count. The byte
  // after it is a blank, a NUL or simply the start of the next token.
  task automatic send_number();
    int n_int;
    int n_frac;
    if ($urandom_range(3) == 0) send_byte(CH_MINUS);
    n_int = ($urandom_range(7) == 0) ? $urandom_range(9, 12) : $urandom_range(0, 4);
    repeat (n_int) send_digit();
    if ($urandom_range(9) < 4) begin
      send_byte(CH_DOT);
      n_frac = $urandom_range(0, 7);
      repeat (n_frac) send_digit();
    end
    case ($urandom_range(4))
      0: ;
      1: send_byte(CH_NUL);
      default: send_byte(pick_blank());
    endcase
  endtask

  // A hash or double-slash comment with printable text, closed by a line end
  // or by the end of the text.
  task automatic send_comment();
    int len;
    if ($urandom_range(1)) begin
      send_byte(CH_HASH);
    end else begin
      send_byte(CH_SLASH);
      send_byte(CH_SLASH);
    end
    len = $urandom_range(0, 6);
    repeat (len) send_byte(CHAR_W'($urandom_range(32, 126)));
    case ($urandom_range(2))
      0: send_byte(CH_LF);
      1: send_byte(CH_CR);
      default: send_byte(CH_NUL);
    endcase
  endtask

  task automatic send_token();
    int pick;
    int len;
    pick = $urandom_range(99);
    if (pick < 55) begin
      send_number();
    end else if (pick < 68) begin
      len = $urandom_range(1, 3);
      repeat (len) send_byte(pick_blank());
    end else if (pick < 78) begin
      send_comment();
    end else if (pick < 83) begin
      send_byte(CH_NUL);
    end else if (pick < 92) begin
      // A sign, dot or slash with nothing useful after it.
      case ($urandom_range(2))
        0: send_byte(CH_MINUS);
        1: send_byte(CH_DOT);
        default: send_byte(CH_SLASH);
      endcase
      send_byte(pick_blank());
    end else begin
      send_byte(CHAR_W'($urandom_range(255)));
    end
  endtask

  // A stretch of random tokens. Somewhere in the middle the sender holds off
  // until the block has handed back every result, and the stretch closes with
  // a NUL so that the scanner is back between tokens before any register write.
  task automatic run_random(input int n);
    int  stop_at;
    int  pause_at;
    bit  paused;
    stop_at  = n_bytes + n;
    pause_at = n_bytes + $urandom_range(n / 4, 3 * n / 4);
    paused   = 1'b0;
    while (n_bytes < stop_at) begin
      if (!paused && n_bytes >= pause_at) begin
        wait_drained();
        paused = 1'b1;
      end
      send_token();
    end
    send_byte(CH_NUL);
  endtask

  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= REG_COMMENTS;
    cfg_wdata       <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.char_code <= CH_NUL;
    src_idle_pct    = 14;
    snk_idle_pct    = 64;
    n_bytes         = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Sender mostly busy, receiver stalling often.
    set_mode(1'b1, 1'b1);
    // Directed text: negative zero, a lone minus, a lone dot, a dot before a
    // digit, a lone slash, a hash comment, the largest integer with more
    // fraction digits than count, a trailing dot, a top-bit byte and NUL.
    send_text("-0 - .x.5/q#c");
    send_byte(CH_LF);
    send_text("2147483647.999996 5.");
    send_byte(8'hFF);
    send_byte(CH_NUL);
    run_random(200);

    // Sender slow, receiver nearly always ready; integer mode both ways.
    src_idle_pct = 64;
    snk_idle_pct = 14;
    set_mode(1'b0, 1'b0);
    run_random(100);
    set_mode(1'b1, 1'b0);
    run_random(100);

    // Full speed on both sides, comments off with fractions on.
    src_idle_pct = 0;
    snk_idle_pct = 0;
    set_mode(1'b0, 1'b1);
    run_random(200);

    wait_drained();
    repeat (SETTLE) @(posedge clk);

    $display("Sent %0d text bytes under four comment and fraction settings and three idle patterns.",
             n_bytes);
    $display("Checked %0d results, %0d of them saturated and %0d malformed tokens.",
             n_results, n_sat, n_bad);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
